// ----- src/sle_pkg.sv -----
// Package: shared constants, command codes and queue types for the serial line editor.
package sle_pkg;

    localparam int LINE_CAP_DEF = 16;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [2:0] KIND_ECHO   = 3'd0;
    localparam logic [2:0] KIND_LINE   = 3'd1;
    localparam logic [2:0] KIND_EOF    = 3'd2;
    localparam logic [2:0] KIND_ERR    = 3'd3;
    localparam logic [2:0] KIND_CANCEL = 3'd4;

    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_HIGH   = 8'hA0;
    localparam logic [7:0] CH_CTRL_C = 8'h03;
    localparam logic [7:0] CH_CTRL_R = 8'h12;
    localparam logic [7:0] CH_CTRL_U = 8'h15;
    localparam logic [7:0] CH_CTRL_W = 8'h17;
    localparam logic [7:0] CH_ZERO   = 8'h00;

    typedef enum logic [3:0] {
        OP_EOF,
        OP_ERR,
        OP_CANCEL,
        OP_LINE,
        OP_STORE,
        OP_ERASE,
        OP_KILL,
        OP_WORD,
        OP_REDRAW,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } op_item_t;

    typedef struct packed {
        logic     valid;
        op_item_t item;
    } q_out_t;

endpackage

// ----- src/sle_ifs.sv -----
// Interfaces: receive-byte channel and result channel.
interface sle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_error;
    logic       overrun;

    modport source (output valid, rx_byte, frame_error, overrun, input ready);
    modport sink   (input valid, rx_byte, frame_error, overrun, output ready);
    modport mon    (input valid, ready, rx_byte, frame_error, overrun);
endinterface

interface sle_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, kind, out_byte, last, input ready);
    modport sink   (input valid, kind, out_byte, last, output ready);
    modport mon    (input valid, ready, kind, out_byte, last);
endinterface

// ----- src/sle_queue.sv -----
// Two-entry command queue between the classifier and the executor.
module sle_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sle_pkg::op_item_t push_item,
    output logic              full,
    input  logic              pop,
    output sle_pkg::q_out_t   head
);

    sle_pkg::op_item_t                 entry_reg [sle_pkg::Q_DEPTH];
    logic [sle_pkg::Q_PTR_W-1:0]       wr_ptr_reg;
    logic [sle_pkg::Q_PTR_W-1:0]       rd_ptr_reg;
    logic [sle_pkg::Q_CNT_W-1:0]       count_reg;
    logic [sle_pkg::Q_CNT_W-1:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full       = (count_reg == sle_pkg::Q_CNT_W'(sle_pkg::Q_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- src/sle_front.sv -----
// Front end: accepts received bytes and turns them into editor commands.
module sle_front (
    sle_in_if.sink            rx,
    input  logic              q_full,
    output logic              push,
    output sle_pkg::op_item_t push_item
);

    logic [7:0] ch;

    assign rx.ready = !q_full;

    always_comb
    begin
        ch = rx.rx_byte;
        if (ch == sle_pkg::CH_CR)
        begin
            ch = sle_pkg::CH_LF;
        end
        if (ch == sle_pkg::CH_TAB)
        begin
            ch = sle_pkg::CH_SP;
        end

        push_item.data = ch;
        if (rx.frame_error)
        begin
            push_item.op = sle_pkg::OP_EOF;
        end
        else if (rx.overrun)
        begin
            push_item.op = sle_pkg::OP_ERR;
        end
        else if ((ch >= sle_pkg::CH_SP && ch <= sle_pkg::CH_TILDE) || ch >= sle_pkg::CH_HIGH)
        begin
            push_item.op = sle_pkg::OP_STORE;
        end
        else
        begin
            unique case (ch) inside
                sle_pkg::CH_LF:               push_item.op = sle_pkg::OP_LINE;
                sle_pkg::CH_CTRL_C:           push_item.op = sle_pkg::OP_CANCEL;
                sle_pkg::CH_BS, sle_pkg::CH_DEL: push_item.op = sle_pkg::OP_ERASE;
                sle_pkg::CH_CTRL_U:           push_item.op = sle_pkg::OP_KILL;
                sle_pkg::CH_CTRL_W:           push_item.op = sle_pkg::OP_WORD;
                sle_pkg::CH_CTRL_R:           push_item.op = sle_pkg::OP_REDRAW;
                default:                      push_item.op = sle_pkg::OP_NOP;
            endcase
        end
    end

    // ignored bytes are consumed here and never reach the queue
    assign push = rx.valid && rx.ready && (push_item.op != sle_pkg::OP_NOP);

endmodule

// ----- src/sle_back.sv -----
// Back end: executes editor commands on the line store and emits result transfers.
module sle_back #(
    parameter int LINE_CAP = sle_pkg::LINE_CAP_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sle_pkg::q_out_t head,
    output logic            pop,
    sle_out_if.source       tx
);

    localparam int IDX_W = $clog2(LINE_CAP);
    localparam logic [IDX_W-1:0] CAP_M1 = IDX_W'(LINE_CAP - 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t            state_reg, state_next;
    sle_pkg::op_item_t op_reg, op_next;
    logic [1:0]        ph_reg, ph_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  fill_reg, fill_next;
    logic              first_reg, first_next;
    logic              cont_reg, cont_next;
    logic              tx_valid_reg, tx_valid_next;
    logic [2:0]        tx_kind_reg, tx_kind_next;
    logic [7:0]        tx_byte_reg, tx_byte_next;
    logic              tx_last_reg, tx_last_next;

    logic [7:0]        store [LINE_CAP];
    logic [IDX_W-1:0]  rd_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic              can_emit;
    logic              emit;
    logic [2:0]        e_kind;
    logic [7:0]        e_byte;
    logic              e_last;
    logic              done;
    logic [IDX_W-1:0]  fill_m1;
    logic [IDX_W-1:0]  fill_m2;

    assign tx.valid    = tx_valid_reg;
    assign tx.kind     = tx_kind_reg;
    assign tx.out_byte = tx_byte_reg;
    assign tx.last     = tx_last_reg;

    assign can_emit = !tx_valid_reg || tx.ready;
    assign fill_m1  = fill_reg - 1'b1;
    assign fill_m2  = fill_reg - 2'd2;

    always_comb
    begin
        if (op_reg.op == sle_pkg::OP_LINE || op_reg.op == sle_pkg::OP_REDRAW)
        begin
            rd_addr = idx_reg;
        end
        else if (ph_reg == 2'd1)
        begin
            rd_addr = fill_m2;
        end
        else
        begin
            rd_addr = fill_m1;
        end
    end

    assign rd_data = store[rd_addr];

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ph_next    = ph_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        first_next = first_reg;
        cont_next  = cont_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        emit       = 1'b0;
        e_kind     = sle_pkg::KIND_ECHO;
        e_byte     = sle_pkg::CH_ZERO;
        e_last     = 1'b0;
        done       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    op_next    = head.item;
                    ph_next    = 2'd0;
                    idx_next   = '0;
                    first_next = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (can_emit)
                begin
                    unique case (op_reg.op)
                        sle_pkg::OP_EOF, sle_pkg::OP_ERR, sle_pkg::OP_CANCEL:
                        begin
                            emit      = 1'b1;
                            e_last    = 1'b1;
                            fill_next = '0;
                            done      = 1'b1;
                            if (op_reg.op == sle_pkg::OP_EOF)
                            begin
                                e_kind = sle_pkg::KIND_EOF;
                            end
                            else if (op_reg.op == sle_pkg::OP_ERR)
                            begin
                                e_kind = sle_pkg::KIND_ERR;
                            end
                            else
                            begin
                                e_kind = sle_pkg::KIND_CANCEL;
                            end
                        end
                        sle_pkg::OP_STORE:
                        begin
                            emit   = 1'b1;
                            e_last = 1'b1;
                            done   = 1'b1;
                            if (fill_reg == CAP_M1)
                            begin
                                e_byte = sle_pkg::CH_BEL;
                            end
                            else
                            begin
                                e_byte    = op_reg.data;
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        sle_pkg::OP_LINE:
                        begin
                            emit = 1'b1;
                            if (ph_reg == 2'd0)
                            begin
                                e_byte  = sle_pkg::CH_CR;
                                ph_next = 2'd1;
                            end
                            else if (ph_reg == 2'd1)
                            begin
                                e_byte  = sle_pkg::CH_LF;
                                ph_next = 2'd2;
                            end
                            else if (idx_reg != fill_reg)
                            begin
                                e_kind   = sle_pkg::KIND_LINE;
                                e_byte   = rd_data;
                                idx_next = idx_reg + 1'b1;
                            end
                            else
                            begin
                                e_kind    = sle_pkg::KIND_LINE;
                                e_byte    = sle_pkg::CH_LF;
                                e_last    = 1'b1;
                                fill_next = '0;
                                done      = 1'b1;
                            end
                        end
                        sle_pkg::OP_REDRAW:
                        begin
                            emit = 1'b1;
                            if (ph_reg == 2'd0)
                            begin
                                e_byte  = sle_pkg::CH_CR;
                                e_last  = (fill_reg == '0);
                                done    = e_last;
                                ph_next = 2'd2;
                            end
                            else
                            begin
                                e_byte   = rd_data;
                                e_last   = (idx_reg == fill_m1);
                                done     = e_last;
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                        sle_pkg::OP_ERASE, sle_pkg::OP_KILL, sle_pkg::OP_WORD:
                        begin
                            if (ph_reg == 2'd0)
                            begin
                                if (first_reg && !(fill_reg != '0 &&
                                    (op_reg.op != sle_pkg::OP_WORD || rd_data != sle_pkg::CH_SP)))
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    emit    = 1'b1;
                                    e_byte  = sle_pkg::CH_BS;
                                    ph_next = 2'd1;
                                end
                            end
                            else if (ph_reg == 2'd1)
                            begin
                                emit    = 1'b1;
                                e_byte  = sle_pkg::CH_SP;
                                ph_next = 2'd2;
                                // look ahead: will another char go after this one
                                if (op_reg.op == sle_pkg::OP_ERASE)
                                begin
                                    cont_next = 1'b0;
                                end
                                else if (op_reg.op == sle_pkg::OP_KILL)
                                begin
                                    cont_next = (fill_reg > IDX_W'(1));
                                end
                                else
                                begin
                                    cont_next = (fill_reg > IDX_W'(1)) && (rd_data != sle_pkg::CH_SP);
                                end
                            end
                            else
                            begin
                                emit       = 1'b1;
                                e_byte     = sle_pkg::CH_BS;
                                e_last     = !cont_reg;
                                fill_next  = fill_m1;
                                first_next = 1'b0;
                                ph_next    = 2'd0;
                                done       = !cont_reg;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        tx_valid_next = tx_valid_reg;
        tx_kind_next  = tx_kind_reg;
        tx_byte_next  = tx_byte_reg;
        tx_last_next  = tx_last_reg;
        if (emit)
        begin
            tx_valid_next = 1'b1;
            tx_kind_next  = e_kind;
            tx_byte_next  = e_byte;
            tx_last_next  = e_last;
        end
        else if (tx.ready)
        begin
            tx_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= '{op: sle_pkg::OP_NOP, data: sle_pkg::CH_ZERO};
            ph_reg       <= '0;
            idx_reg      <= '0;
            fill_reg     <= '0;
            first_reg    <= 1'b0;
            cont_reg     <= 1'b0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            ph_reg       <= ph_next;
            idx_reg      <= idx_next;
            fill_reg     <= fill_next;
            first_reg    <= first_next;
            cont_reg     <= cont_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_kind_reg <= tx_kind_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[fill_reg] <= op_reg.data;
        end
    end

endmodule

// ----- src/serial_line_editor.sv -----
// Top level: serial line editor with decoupled classifier and executor.
//
// Channels: rx carries one received byte with its framing-error and overrun
// flags; tx carries results (kind, out_byte, last), last marking the final
// result of one received byte. A transfer happens when valid and ready are high.
// Order: a byte enters the command queue in the cycle it is taken; the
// executor then loads it from the queue head into its command register
// and emits one result per cycle through the output register while tx
// is not stalled. A byte gives 0 to 3*(LINE_CAP-1) results; a line
// delivery gives fill+3, a redraw fill+1. The executor sequencer takes a
// new command only when it has finished the last; ignored control bytes
// are dropped in the front and cost nothing after the transfer.
// rx.ready stays high while the two-entry command queue has room.
// Reset clears the fill count, the queue and the output valid flag; the line
// store holds no defined value but is only read below the fill count.
// A stalled receiver holds the output register; the executor then waits,
// the queue fills and rx.ready drops.
module serial_line_editor #(
    parameter int LINE_CAP = sle_pkg::LINE_CAP_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sle_in_if.sink    rx,
    sle_out_if.source tx
);

    logic              q_full;
    logic              push;
    sle_pkg::op_item_t push_item;
    logic              pop;
    sle_pkg::q_out_t   head;

    sle_front u_front (
        .rx        (rx),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    sle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    sle_back #(
        .LINE_CAP (LINE_CAP)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .tx    (tx)
    );

endmodule

// ----- src/sle_checker.sv -----
// Checker: port-level properties of the serial line editor, bound to the top level.
module sle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tx_valid,
    input logic       tx_ready,
    input logic [2:0] tx_kind,
    input logic [7:0] tx_out_byte,
    input logic       tx_last
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> $stable(tx_kind) && $stable(tx_out_byte) && $stable(tx_last))
        else $error("result payload changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid |-> tx_kind <= sle_pkg::KIND_CANCEL)
        else $error("result kind out of range");

    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (tx_kind == sle_pkg::KIND_EOF || tx_kind == sle_pkg::KIND_ERR ||
                     tx_kind == sle_pkg::KIND_CANCEL)
        |-> tx_last && tx_out_byte == sle_pkg::CH_ZERO)
        else $error("status result not single and zero");

    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_kind == sle_pkg::KIND_LINE && tx_last |-> tx_out_byte == sle_pkg::CH_LF)
        else $error("delivered line does not end in LF");

endmodule

bind serial_line_editor sle_checker u_sle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tx_valid    (tx.valid),
    .tx_ready    (tx.ready),
    .tx_kind     (tx.kind),
    .tx_out_byte (tx.out_byte),
    .tx_last     (tx.last)
);

// ----- test/tb_top.sv -----
// Testbench for serial_line_editor: directed table and random edit sessions checked against a line predictor.
module tb_top;
    import sle_pkg::*;

    localparam int CAP = LINE_CAP_DEF;
    localparam int QUIET_LIMIT = 500;
    localparam int TAIL_CYCLES = 40;
    localparam int BUSY_TARGET = 310;
    localparam bit CHK = 1'b1;
    localparam bit PRD = 1'b0;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } tx_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fe;
        logic       ovr;
        logic [4:0] reps;
        logic       typed;
        logic [1:0] n_res;
        logic [2:0] kind;
        logic [7:0] res_byte;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    sle_in_if  rx_ch ();
    sle_out_if tx_ch ();

    serial_line_editor #(.LINE_CAP(CAP)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // editor state as seen by the predictor
    logic [7:0] line_buf [CAP];
    int         line_len = 0;
    tx_item_t   step_res [64];
    int         step_n;
    tx_item_t   due_results [$];

    int n_bad = 0;
    int quiet_cycles = 0;
    bit stuck = 1'b0;
    int rx_calm = 0;
    int tx_calm = 0;

    stim_row_t directed_rows [25] = '{
        '{CH_CR,     1'b1, 1'b0, 5'd1,  CHK, 2'd1, KIND_EOF,    CH_ZERO},
        '{8'h41,     1'b0, 1'b1, 5'd1,  CHK, 2'd1, KIND_ERR,    CH_ZERO},
        '{8'hFF,     1'b1, 1'b1, 5'd1,  CHK, 2'd1, KIND_EOF,    CH_ZERO},
        '{CH_CTRL_C, 1'b0, 1'b0, 5'd1,  CHK, 2'd1, KIND_CANCEL, CH_ZERO},
        '{CH_BS,     1'b0, 1'b0, 5'd1,  CHK, 2'd0, KIND_ECHO,   CH_ZERO},
        '{CH_CTRL_U, 1'b0, 1'b0, 5'd1,  CHK, 2'd0, KIND_ECHO,   CH_ZERO},
        '{CH_ZERO,   1'b0, 1'b0, 5'd1,  CHK, 2'd0, KIND_ECHO,   CH_ZERO},
        '{8'h9F,     1'b0, 1'b0, 5'd1,  CHK, 2'd0, KIND_ECHO,   CH_ZERO},
        '{CH_CTRL_R, 1'b0, 1'b0, 5'd1,  CHK, 2'd1, KIND_ECHO,   CH_CR},
        '{CH_LF,     1'b0, 1'b0, 5'd1,  PRD, 2'd0, KIND_ECHO,   CH_ZERO},
        '{CH_SP,     1'b0, 1'b0, 5'd1,  CHK, 2'd1, KIND_ECHO,   CH_SP},
        '{CH_TILDE,  1'b0, 1'b0, 5'd1,  CHK, 2'd1, KIND_ECHO,   CH_TILDE},
        '{CH_HIGH,   1'b0, 1'b0, 5'd1,  CHK, 2'd1, KIND_ECHO,   CH_HIGH},
        '{8'hFF,     1'b0, 1'b0, 5'd1,  CHK, 2'd1, KIND_ECHO,   8'hFF},
        '{CH_TAB,    1'b0, 1'b0, 5'd1,  CHK, 2'd1, KIND_ECHO,   CH_SP},
        '{8'h61,     1'b0, 1'b0, 5'd1,  CHK, 2'd1, KIND_ECHO,   8'h61},
        '{CH_CTRL_W, 1'b0, 1'b0, 5'd1,  PRD, 2'd0, KIND_ECHO,   CH_ZERO},
        '{CH_CTRL_W, 1'b0, 1'b0, 5'd1,  CHK, 2'd0, KIND_ECHO,   CH_ZERO},
        '{CH_DEL,    1'b0, 1'b0, 5'd1,  PRD, 2'd0, KIND_ECHO,   CH_ZERO},
        '{CH_CTRL_R, 1'b0, 1'b0, 5'd1,  PRD, 2'd0, KIND_ECHO,   CH_ZERO},
        '{CH_CR,     1'b0, 1'b0, 5'd1,  PRD, 2'd0, KIND_ECHO,   CH_ZERO},
        '{8'h78,     1'b0, 1'b0, 5'd15, CHK, 2'd1, KIND_ECHO,   8'h78},
        '{8'h79,     1'b0, 1'b0, 5'd1,  CHK, 2'd1, KIND_ECHO,   CH_BEL},
        '{CH_CTRL_R, 1'b0, 1'b0, 5'd1,  PRD, 2'd0, KIND_ECHO,   CH_ZERO},
        '{CH_CTRL_U, 1'b0, 1'b0, 5'd1,  PRD, 2'd0, KIND_ECHO,   CH_ZERO}
    };

    function automatic void put(input logic [2:0] kind, input logic [7:0] data);
        step_res[step_n] = '{kind: kind, data: data, last: 1'b0};
        step_n++;
    endfunction

    function automatic void erase_char();
        put(KIND_ECHO, CH_BS);
        put(KIND_ECHO, CH_SP);
        put(KIND_ECHO, CH_BS);
        line_len--;
    endfunction

    function automatic void edit_line(input logic [7:0] b, input logic fe, input logic ovr);
        logic [7:0] c;
        c = b;
        step_n = 0;
        if (fe)
        begin
            line_len = 0;
            put(KIND_EOF, CH_ZERO);
        end
        else if (ovr)
        begin
            line_len = 0;
            put(KIND_ERR, CH_ZERO);
        end
        else
        begin
            if (c == CH_CR)
                c = CH_LF;
            if (c == CH_TAB)
                c = CH_SP;
            if (c == CH_LF)
            begin
                put(KIND_ECHO, CH_CR);
                put(KIND_ECHO, CH_LF);
                for (int i = 0; i < line_len; i++)
                    put(KIND_LINE, line_buf[i]);
                put(KIND_LINE, CH_LF);
                line_len = 0;
            end
            else if ((c >= CH_SP && c <= CH_TILDE) || c >= CH_HIGH)
            begin
                if (line_len >= CAP - 1)
                    put(KIND_ECHO, CH_BEL);
                else
                begin
                    line_buf[line_len] = c;
                    line_len++;
                    put(KIND_ECHO, c);
                end
            end
            else if (c == CH_CTRL_C)
            begin
                line_len = 0;
                put(KIND_CANCEL, CH_ZERO);
            end
            else if (c == CH_BS || c == CH_DEL)
            begin
                if (line_len > 0)
                    erase_char();
            end
            else if (c == CH_CTRL_R)
            begin
                put(KIND_ECHO, CH_CR);
                for (int i = 0; i < line_len; i++)
                    put(KIND_ECHO, line_buf[i]);
            end
            else if (c == CH_CTRL_U)
            begin
                while (line_len > 0)
                    erase_char();
            end
            else if (c == CH_CTRL_W)
            begin
                while (line_len > 0 && line_buf[line_len - 1] != CH_SP)
                    erase_char();
            end
        end
        if (step_n > 0)
            step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            due_results.push_back(step_res[i]);
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [7:0] pick_printable();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return CH_SP;
        if (r < 7)
            return 8'($urandom_range(8'h21, CH_TILDE));
        return 8'($urandom_range(CH_HIGH, 8'hFF));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fe, input logic ovr,
                             output int n);
        int w;
        w = draw_wait(rx_calm);
        if (w > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_error <= fe;
        rx_ch.overrun     <= ovr;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        edit_line(b, fe, ovr);
        n = step_n;
    endtask

    // result sink with random stalls
    initial
    begin
        int w;
        tx_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            w = draw_wait(tx_calm);
            if (w > 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            tx_ch.ready <= 1'b1;
            @(posedge clk);
            while (!tx_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        tx_item_t e;
        if (tx_ch.valid && tx_ch.ready)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected transfer: kind %0d out_byte %02h last %0b",
                       tx_ch.kind, tx_ch.out_byte, tx_ch.last);
                n_bad++;
            end
            else
            begin
                e = due_results.pop_front();
                if (tx_ch.kind !== e.kind)
                begin
                    $error("kind: expected %0d, got %0d", e.kind, tx_ch.kind);
                    n_bad++;
                end
                if (tx_ch.out_byte !== e.data)
                begin
                    $error("out_byte: expected %02h, got %02h", e.data, tx_ch.out_byte);
                    n_bad++;
                end
                if (tx_ch.last !== e.last)
                begin
                    $error("last: expected %0b, got %0b", e.last, tx_ch.last);
                    n_bad++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
            stuck <= 1'b1;
    end

    initial
    begin
        int n;
        int len;
        int r;
        int busy;
        logic [7:0] b;
        logic fe;
        logic ovr;
        stim_row_t row;
        rst_n             <= 1'b0;
        rx_ch.valid       <= 1'b0;
        rx_ch.rx_byte     <= CH_ZERO;
        rx_ch.frame_error <= 1'b0;
        rx_ch.overrun     <= 1'b0;
        fork
            begin
                repeat (2) @(posedge clk);
                rst_n <= 1'b1;
                foreach (directed_rows[i])
                begin
                    row = directed_rows[i];
                    for (int k = 0; k < row.reps; k++)
                    begin
                        send_byte(row.data, row.fe, row.ovr, n);
                        if (row.typed && n != row.n_res)
                        begin
                            $error("row %0d result count: expected %0d, got %0d",
                                   i, row.n_res, n);
                            n_bad++;
                        end
                        else if (row.typed && n == 1 && step_res[0].kind != row.kind)
                        begin
                            $error("row %0d kind: expected %0d, got %0d",
                                   i, row.kind, step_res[0].kind);
                            n_bad++;
                        end
                        else if (row.typed && n == 1 && step_res[0].data != row.res_byte)
                        begin
                            $error("row %0d out_byte: expected %02h, got %02h",
                                   i, row.res_byte, step_res[0].data);
                            n_bad++;
                        end
                    end
                end

                // edit sessions: mostly typed text with edits, usually closed by a line end
                busy = 0;
                while (busy < BUSY_TARGET)
                begin
                    len = $urandom_range(0, 20);
                    for (int k = 0; k < len; k++)
                    begin
                        r = $urandom_range(0, 99);
                        fe = 1'b0;
                        ovr = 1'b0;
                        if (r < 80)
                            b = pick_printable();
                        else if (r < 86)
                            b = $urandom_range(0, 1) ? CH_BS : CH_DEL;
                        else if (r < 89)
                            b = CH_CTRL_W;
                        else if (r < 91)
                            b = CH_CTRL_R;
                        else if (r < 93)
                            b = CH_TAB;
                        else if (r < 95)
                            b = CH_CTRL_U;
                        else
                        begin
                            b = 8'($urandom_range(0, 255));
                            if (r == 99)
                            begin
                                fe = 1'($urandom_range(0, 1));
                                ovr = 1'($urandom_range(0, 1));
                            end
                        end
                        send_byte(b, fe, ovr, n);
                        busy++;
                    end
                    r = $urandom_range(0, 19);
                    fe = 1'b0;
                    ovr = 1'b0;
                    if (r < 13)
                        b = $urandom_range(0, 1) ? CH_CR : CH_LF;
                    else if (r < 15)
                        b = CH_CTRL_C;
                    else if (r == 15)
                    begin
                        b = 8'($urandom_range(0, 255));
                        fe = 1'b1;
                        ovr = 1'($urandom_range(0, 1));
                    end
                    else if (r == 16)
                    begin
                        b = 8'($urandom_range(0, 255));
                        ovr = 1'b1;
                    end
                    else if (r == 17)
                        b = CH_CTRL_U;
                    else if (r == 18)
                        b = CH_CTRL_R;
                    else
                        b = 8'($urandom_range(0, 255));
                    send_byte(b, fe, ovr, n);
                    busy++;
                end
                rx_ch.valid <= 1'b0;
                while (due_results.size() != 0)
                    @(posedge clk);
                repeat (TAIL_CYCLES) @(posedge clk);
            end
            begin
                wait (stuck);
            end
        join_any
        if (n_bad == 0 && !stuck)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
